@@ rtl/cwpa_pkg.sv @@
// ----------------------------------------------------------------------------
// cwpa_pkg
// Shared types, constants and helpers for the cache way partition allocator.
// ----------------------------------------------------------------------------
package cwpa_pkg;

	localparam int MAX_WAYS   = 32;
	localparam int WAY_W      = 6;    // holds a way count up to MAX_WAYS
	localparam int WIDX_W     = 5;    // way index
	localparam int MAX_CLS    = 16;
	localparam int CLS_W      = 4;    // class index
	localparam int CLSN_W     = 5;    // class count
	localparam int CNT_W      = 16;
	localparam int PCT_W      = 7;
	localparam int MASK_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;
	localparam int X_W        = 12;   // ways times percent
	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	// reciprocal of 100 for x below 4096: floor(x * 1311 / 2^17)
	localparam int RECIP_W     = 23;
	localparam int RECIP_SHIFT = 17;
	localparam logic [RECIP_W-1:0] RECIP_100 = 23'd1311;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAY_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLS_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THREAD_PCT = 3'd3;

	typedef enum logic [1:0] {
		MD_START   = 2'd0,
		MD_ACQUIRE = 2'd1,
		MD_SELECT  = 2'd2,
		MD_RELEASE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_REFUSED   = 3'd1,
		ST_NO_IDLE   = 3'd2,
		ST_NO_ROOM   = 3'd3,
		ST_PROTECTED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		RK_PLAIN  = 2'd0,
		RK_ACQ    = 2'd1,
		RK_START0 = 2'd2,
		RK_START1 = 2'd3
	} res_kind_t;

	typedef enum logic [1:0] {
		TC_CUR  = 2'd0,
		TC_ZERO = 2'd1,
		TC_FULL = 2'd2,
		TC_IDX  = 2'd3
	} tc_sel_t;

	typedef struct packed {
		logic      latch;
		logic      rel_do;
		logic      rel_idx;
		logic      sh1;
		logic      sh2;
		logic      find;
		logic      scan_clr;
		logic      scan_step;
		logic      commit;
		logic      start_wr;
		logic      join_do;
		logic      res_ld;
		res_kind_t kind;
		status_t   st;
		tc_sel_t   tc;
	} cmd_t;

	typedef struct packed {
		mode_t   mode;
		logic    en;
		logic    pct_bad;
		logic    pct_full;
		logic    cur_nz;
		status_t rel_idx_st;
		status_t rel_cur_st;
		logic    sel_bad;
		logic    idx_is1;
		logic    len_zero;
		logic    idle_found;
		logic    scan_hit;
		logic    scan_end;
	} stat_t;

	function automatic logic [MASK_W-1:0] run_mask(logic [WAY_W-1:0] base,
			logic [WAY_W-1:0] len);
		logic [MASK_W-1:0] m;
		m = '0;
		if (len != '0 && base < WAY_W'(MASK_W)) begin
			if (len >= WAY_W'(MASK_W))
				m = '1;
			else
				m = (MASK_W'(1) << len) - MASK_W'(1);
			m = m << base;
		end
		return m;
	endfunction

endpackage

@@ rtl/cwpa_if.sv @@
// ----------------------------------------------------------------------------
// cwpa request and result channels
// Valid/ready channels carrying allocator requests and results.
// ----------------------------------------------------------------------------
interface cwpa_req_if;
	import cwpa_pkg::*;
	logic             valid;
	logic             ready;
	logic [1:0]       mode;
	logic [7:0]       percent;
	logic [CLS_W-1:0] class_index;
	logic [CLS_W-1:0] current_class;

	modport source(output valid, mode, percent, class_index, current_class, input ready);
	modport sink(input valid, mode, percent, class_index, current_class, output ready);
endinterface

interface cwpa_res_if;
	import cwpa_pkg::*;
	logic              valid;
	logic              ready;
	logic [2:0]        status;
	logic [CLS_W-1:0]  thread_class;
	logic              mask_write;
	logic [CLS_W-1:0]  mask_class;
	logic [MASK_W-1:0] mask_bits;
	logic              last;

	modport source(output valid, status, thread_class, mask_write, mask_class, mask_bits,
		last, input ready);
	modport sink(input valid, status, thread_class, mask_write, mask_class, mask_bits,
		last, output ready);
endinterface

@@ rtl/cwpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// cwpa_ctrl
// Request sequencer: decodes a request and steps the datapath through it.
// ----------------------------------------------------------------------------
module cwpa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	output logic            res_valid,
	input  logic            res_ready,
	input  cwpa_pkg::stat_t stat,
	output cwpa_pkg::cmd_t  cmd
);
	import cwpa_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_DEC    = 10'b0000000010,
		S_SH1    = 10'b0000000100,
		S_SH2    = 10'b0000001000,
		S_FIND   = 10'b0000010000,
		S_SCAN   = 10'b0000100000,
		S_START  = 10'b0001000000,
		S_JOIN   = 10'b0010000000,
		S_OUT    = 10'b0100000000,
		S_SPARE  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   more_q, more_d;

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_OUT);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		more_d  = more_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DEC;
				end
			end
			S_DEC: begin
				case (stat.mode)
					MD_START: begin
						if (!stat.en) begin
							cmd.res_ld = 1'b1;
							cmd.st     = ST_OK;
							cmd.tc     = TC_CUR;
							state_d    = S_OUT;
						end else begin
							state_d = S_SH1;
						end
					end
					MD_ACQUIRE: begin
						if (!stat.en || stat.pct_bad) begin
							cmd.res_ld = 1'b1;
							cmd.st     = ST_REFUSED;
							cmd.tc     = TC_CUR;
							state_d    = S_OUT;
						end else if (stat.cur_nz && stat.rel_cur_st != ST_OK) begin
							cmd.res_ld = 1'b1;
							cmd.st     = stat.rel_cur_st;
							cmd.tc     = TC_CUR;
							state_d    = S_OUT;
						end else begin
							cmd.rel_do = stat.cur_nz;
							if (stat.pct_full) begin
								cmd.res_ld = 1'b1;
								cmd.st     = ST_OK;
								cmd.tc     = TC_FULL;
								state_d    = S_OUT;
							end else begin
								state_d = S_SH1;
							end
						end
					end
					MD_SELECT: begin
						if (stat.sel_bad || stat.idx_is1) begin
							cmd.res_ld = 1'b1;
							cmd.st     = stat.sel_bad ? ST_REFUSED : ST_PROTECTED;
							cmd.tc     = TC_CUR;
							state_d    = S_OUT;
						end else begin
							// a failed release of the old class is ignored
							cmd.rel_do = stat.cur_nz && stat.rel_cur_st == ST_OK;
							state_d    = S_JOIN;
						end
					end
					MD_RELEASE: begin
						cmd.res_ld  = 1'b1;
						cmd.st      = stat.rel_idx_st;
						cmd.tc      = (stat.rel_idx_st == ST_OK) ? TC_ZERO : TC_CUR;
						cmd.rel_do  = (stat.rel_idx_st == ST_OK);
						cmd.rel_idx = 1'b1;
						state_d     = S_OUT;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_SH1: begin
				cmd.sh1 = 1'b1;
				state_d = S_SH2;
			end
			S_SH2: begin
				cmd.sh2 = 1'b1;
				state_d = (stat.mode == MD_START) ? S_START : S_FIND;
			end
			S_START: begin
				cmd.start_wr = 1'b1;
				cmd.res_ld   = 1'b1;
				cmd.kind     = RK_START0;
				more_d       = 1'b1;
				state_d      = S_OUT;
			end
			S_FIND: begin
				if (!stat.idle_found || stat.len_zero) begin
					cmd.res_ld = 1'b1;
					cmd.st     = stat.idle_found ? ST_NO_ROOM : ST_NO_IDLE;
					cmd.tc     = TC_ZERO;
					state_d    = S_OUT;
				end else begin
					cmd.find     = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d      = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.scan_hit) begin
					cmd.commit = 1'b1;
					cmd.res_ld = 1'b1;
					cmd.kind   = RK_ACQ;
					state_d    = S_OUT;
				end else if (stat.scan_end) begin
					cmd.res_ld = 1'b1;
					cmd.st     = ST_NO_ROOM;
					cmd.tc     = TC_ZERO;
					state_d    = S_OUT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_JOIN: begin
				cmd.join_do = 1'b1;
				cmd.res_ld  = 1'b1;
				cmd.st      = ST_OK;
				cmd.tc      = TC_IDX;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (res_ready) begin
					if (more_q) begin
						// second mask write of a start request
						cmd.res_ld = 1'b1;
						cmd.kind   = RK_START1;
						more_d     = 1'b0;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			more_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			more_q  <= more_d;
		end
	end

endmodule

@@ rtl/cwpa_dp.sv @@
// ----------------------------------------------------------------------------
// cwpa_dp
// Class and way tables, configuration, share arithmetic, run scan, results.
// ----------------------------------------------------------------------------
module cwpa_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cwpa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cwpa_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [1:0]                          in_mode,
	input  logic [7:0]                          in_percent,
	input  logic [cwpa_pkg::CLS_W-1:0]          in_class_index,
	input  logic [cwpa_pkg::CLS_W-1:0]          in_current_class,
	input  cwpa_pkg::cmd_t                      cmd,
	output cwpa_pkg::stat_t                     stat,
	output logic [2:0]                          status,
	output logic [cwpa_pkg::CLS_W-1:0]          thread_class,
	output logic                                mask_write,
	output logic [cwpa_pkg::CLS_W-1:0]          mask_class,
	output logic [cwpa_pkg::MASK_W-1:0]         mask_bits,
	output logic                                last
);
	import cwpa_pkg::*;

	logic                en_q;
	logic [WAY_W-1:0]    wc_q;
	logic [CLSN_W-1:0]   cc_q;
	logic [PCT_W-1:0]    tpct_q;

	mode_t               mode_q;
	logic [7:0]          pct_q;
	logic [CLS_W-1:0]    idx_q, cur_q;

	logic [CNT_W-1:0]    way_cnt_q [MAX_WAYS];
	logic [CNT_W-1:0]    cls_cnt_q [MAX_CLS];
	logic [MASK_W-1:0]   cls_mask_q [MAX_CLS];

	logic [X_W-1:0]      x_s1;
	logic [WAY_W-1:0]    len_q, way_q, run_q;
	logic [CLS_W-1:0]    idle_q;

	logic [WAY_W-1:0]    w_eff;
	logic [CLSN_W-1:0]   c_eff;
	logic [CLS_W-1:0]    full_cls;
	logic [MASK_W-1:0]   wmask, mask0, acq_mask, adj_mask;
	logic [PCT_W-1:0]    pct_src;
	logic [RECIP_W-1:0]  prod;
	logic [WAY_W-1:0]    quo, share_len, run_n, acq_base;
	logic [X_W-1:0]      quo_x100;
	logic                idle_found, free_way;
	logic [CLS_W-1:0]    idle_cls, rel_cls, cnt_cls;
	logic                adj_up, adj_dn, cnt_up, cnt_dn, join_cnt;

	function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + CNT_W'(1);
	endfunction

	function automatic logic [CNT_W-1:0] sat_dec(logic [CNT_W-1:0] v);
		return (v == '0) ? v : v - CNT_W'(1);
	endfunction

	function automatic status_t rel_status(logic [CLS_W-1:0] cls);
		status_t s;
		if (!en_q || {1'b0, cls} >= c_eff || cls_cnt_q[cls] == '0 || cur_q != cls)
			s = ST_REFUSED;
		else if (cls == CLS_W'(0) || cls == CLS_W'(1) || cls == full_cls)
			s = ST_PROTECTED;
		else
			s = ST_OK;
		return s;
	endfunction

	// effective configuration
	always_comb begin
		if (wc_q == '0)
			w_eff = WAY_W'(1);
		else if (wc_q > WAY_W'(MAX_WAYS))
			w_eff = WAY_W'(MAX_WAYS);
		else
			w_eff = wc_q;
		if (cc_q < CLSN_W'(3))
			c_eff = CLSN_W'(3);
		else if (cc_q > CLSN_W'(MAX_CLS))
			c_eff = CLSN_W'(MAX_CLS);
		else
			c_eff = cc_q;
	end

	assign full_cls = CLS_W'(c_eff - CLSN_W'(1));
	assign wmask    = run_mask('0, w_eff);

	// ceil(ways * percent / 100)
	assign pct_src   = (mode_q == MD_START) ? ((tpct_q > PCT_FULL) ? PCT_FULL : tpct_q)
		: pct_q[PCT_W-1:0];
	assign prod      = RECIP_W'(x_s1) * RECIP_100;
	assign quo       = WAY_W'(prod >> RECIP_SHIFT);
	assign quo_x100  = X_W'(quo) * X_W'(PCT_FULL);
	assign share_len = quo + WAY_W'(x_s1 != quo_x100);

	// lowest class with a zero count
	always_comb begin
		idle_found = 1'b0;
		idle_cls   = '0;
		for (int i = MAX_CLS - 1; i >= 0; i--) begin
			if (CLSN_W'(i) < c_eff && cls_cnt_q[i] == '0) begin
				idle_found = 1'b1;
				idle_cls   = CLS_W'(i);
			end
		end
	end

	// run scan, one way a cycle
	assign free_way = (way_cnt_q[way_q[WIDX_W-1:0]] == '0);
	assign run_n    = free_way ? run_q + WAY_W'(1) : '0;
	assign acq_base = way_q + WAY_W'(1) - len_q;
	assign acq_mask = run_mask(acq_base, len_q);
	assign mask0    = (len_q <= w_eff) ? run_mask('0, len_q) : '0;

	assign rel_cls  = cmd.rel_idx ? idx_q : cur_q;
	assign join_cnt = idx_q != '0 && idx_q != full_cls;

	always_comb begin
		adj_up   = 1'b0;
		adj_dn   = 1'b0;
		adj_mask = '0;
		cnt_up   = 1'b0;
		cnt_dn   = 1'b0;
		cnt_cls  = '0;
		if (cmd.rel_do) begin
			adj_dn   = 1'b1;
			adj_mask = cls_mask_q[rel_cls];
			cnt_dn   = 1'b1;
			cnt_cls  = rel_cls;
		end else if (cmd.commit) begin
			adj_up   = 1'b1;
			adj_mask = acq_mask;
			cnt_up   = 1'b1;
			cnt_cls  = idle_q;
		end else if (cmd.start_wr) begin
			adj_up   = 1'b1;
			adj_mask = mask0;
		end else if (cmd.join_do && join_cnt) begin
			adj_up   = 1'b1;
			adj_mask = cls_mask_q[idx_q];
			cnt_up   = 1'b1;
			cnt_cls  = idx_q;
		end
		adj_mask = adj_mask & wmask;
	end

	always_comb begin
		stat            = '0;
		stat.mode       = mode_q;
		stat.en         = en_q;
		stat.pct_bad    = pct_q > 8'(PCT_FULL);
		stat.pct_full   = pct_q == 8'(PCT_FULL);
		stat.cur_nz     = cur_q != '0;
		stat.rel_idx_st = rel_status(idx_q);
		stat.rel_cur_st = rel_status(cur_q);
		stat.sel_bad    = !en_q || {1'b0, idx_q} >= c_eff || cls_cnt_q[idx_q] == '0;
		stat.idx_is1    = idx_q == CLS_W'(1);
		stat.len_zero   = len_q == '0;
		stat.idle_found = idle_found;
		stat.scan_end   = way_q >= w_eff;
		stat.scan_hit   = way_q < w_eff && run_n == len_q;
	end

	// configuration and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 1'b1;
			wc_q   <= WAY_W'(20);
			cc_q   <= CLSN_W'(16);
			tpct_q <= PCT_W'(50);
			for (int i = 0; i < MAX_WAYS; i++)
				way_cnt_q[i] <= '0;
			for (int i = 0; i < MAX_CLS; i++) begin
				cls_cnt_q[i]  <= '0;
				cls_mask_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ENABLED:    en_q   <= cfg_data[0];
					CFG_WAY_COUNT:  wc_q   <= cfg_data[WAY_W-1:0];
					CFG_CLS_COUNT:  cc_q   <= cfg_data[CLSN_W-1:0];
					CFG_THREAD_PCT: tpct_q <= cfg_data[PCT_W-1:0];
					default: ;
				endcase
			end
			for (int i = 0; i < MAX_WAYS; i++) begin
				if (adj_mask[i]) begin
					if (adj_up)
						way_cnt_q[i] <= sat_inc(way_cnt_q[i]);
					else if (adj_dn)
						way_cnt_q[i] <= sat_dec(way_cnt_q[i]);
				end
			end
			if (cnt_up)
				cls_cnt_q[cnt_cls] <= sat_inc(cls_cnt_q[cnt_cls]);
			else if (cnt_dn)
				cls_cnt_q[cnt_cls] <= sat_dec(cls_cnt_q[cnt_cls]);
			if (cmd.commit)
				cls_mask_q[idle_q] <= acq_mask;
			if (cmd.start_wr) begin
				cls_mask_q[0]        <= mask0;
				cls_cnt_q[0]         <= sat_inc(cls_cnt_q[0]);
				cls_mask_q[full_cls] <= wmask;
				cls_cnt_q[full_cls]  <= sat_inc(cls_cnt_q[full_cls]);
			end
		end
	end

	// request and working registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q <= mode_t'(in_mode);
			pct_q  <= in_percent;
			idx_q  <= in_class_index;
			cur_q  <= in_current_class;
		end
		if (cmd.sh1)
			x_s1 <= X_W'(w_eff) * X_W'(pct_src);
		if (cmd.sh2)
			len_q <= share_len;
		if (cmd.find)
			idle_q <= idle_cls;
		if (cmd.scan_clr) begin
			way_q <= '0;
			run_q <= '0;
		end else if (cmd.scan_step) begin
			way_q <= way_q + WAY_W'(1);
			run_q <= run_n;
		end
		if (cmd.res_ld) begin
			case (cmd.kind)
				RK_ACQ: begin
					status       <= ST_OK;
					thread_class <= idle_q;
					mask_write   <= 1'b1;
					mask_class   <= idle_q;
					mask_bits    <= acq_mask;
					last         <= 1'b1;
				end
				RK_START0: begin
					status       <= ST_OK;
					thread_class <= '0;
					mask_write   <= 1'b1;
					mask_class   <= '0;
					mask_bits    <= mask0;
					last         <= 1'b0;
				end
				RK_START1: begin
					status       <= ST_OK;
					thread_class <= '0;
					mask_write   <= 1'b1;
					mask_class   <= full_cls;
					mask_bits    <= cls_mask_q[full_cls];
					last         <= 1'b1;
				end
				default: begin
					status     <= cmd.st;
					mask_write <= 1'b0;
					mask_class <= '0;
					mask_bits  <= '0;
					last       <= 1'b1;
					case (cmd.tc)
						TC_CUR:  thread_class <= cur_q;
						TC_ZERO: thread_class <= '0;
						TC_FULL: thread_class <= full_cls;
						TC_IDX:  thread_class <= idx_q;
						default: thread_class <= '0;
					endcase
				end
			endcase
		end
	end

endmodule

@@ rtl/cache_way_partition_allocator.sv @@
// ----------------------------------------------------------------------------
// cache_way_partition_allocator
// Service class and cache way mask allocator with saturating reference counts.
// ----------------------------------------------------------------------------
// usage:
// - req channel takes one request (mode, percent, class_index, current_class)
//   when valid and ready are high; ready is high only while the block is idle
// - res channel returns one result per request, two for a start while enabled
//   (class 0 mask write, then the full-class mask write); last marks the end
// - cfg_we/cfg_index/cfg_data write the configuration registers; the user must write
//   them only while idle, since the block itself does not enforce it
// - refused and release requests and an acquire of 100 percent go from decode to the
//   result, a select through the join step, a start through the share and start steps;
//   an acquire goes through the share steps, the idle class search and the run scan
// - the run scan walks the way counts one way a cycle and sets the acquire time;
//   one request at a time, the next one is taken the cycle after the last result
// - results sit in an output register; a stalled receiver holds the block in
//   its result state and no new request is taken until the last result leaves
// - reset clears all counts and masks and loads the configuration defaults
// ----------------------------------------------------------------------------
module cache_way_partition_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	cwpa_req_if.sink                          req,
	cwpa_res_if.source                        res,
	input  logic                              cfg_we,
	input  logic [cwpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cwpa_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import cwpa_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	cwpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	cwpa_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_mode          (req.mode),
		.in_percent       (req.percent),
		.in_class_index   (req.class_index),
		.in_current_class (req.current_class),
		.cmd              (cmd),
		.stat             (stat),
		.status           (res.status),
		.thread_class     (res.thread_class),
		.mask_write       (res.mask_write),
		.mask_class       (res.mask_class),
		.mask_bits        (res.mask_bits),
		.last             (res.last)
	);

endmodule

@@ tb/sv/tb_cache_way_partition_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_cache_way_partition_allocator
// Self-checking bench for the way partition allocator: start, acquire, select
// and release requests under several settings, each result checked field by
// field against a predicted class and way count table.
// ----------------------------------------------------------------------------
module tb_cache_way_partition_allocator;
	timeunit 1ns;
	timeprecision 1ps;
	import cwpa_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_INT_PCT = 3'd4;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		status_t           st;
		logic [CLS_W-1:0]  tc;
		logic              mw;
		logic [CLS_W-1:0]  mc;
		logic [MASK_W-1:0] mb;
		logic              last;
	} alloc_res_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cwpa_req_if req();
	cwpa_res_if res();

	cache_way_partition_allocator dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .res(res.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predicted block state
	logic              en_q;
	logic [5:0]        ways_q;
	logic [4:0]        classes_q;
	logic [6:0]        tpct_q, ipct_q;
	logic [CNT_W-1:0]  way_ref [MAX_WAYS];
	logic [CNT_W-1:0]  cls_ref [MAX_CLS];
	logic [MASK_W-1:0] cls_mask [MAX_CLS];

	alloc_res_t expected_q[$];
	logic [CLS_W-1:0] thread_cls;
	int errors = 0, cycles = 0;
	bit idle_on;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int eff_ways();
		if (ways_q == 0) return 1;
		return ways_q > MAX_WAYS ? MAX_WAYS : ways_q;
	endfunction

	function automatic int eff_classes();
		if (classes_q < 3) return 3;
		return classes_q > MAX_CLS ? MAX_CLS : classes_q;
	endfunction

	function automatic int share_of(int pct);
		int x;
		x = eff_ways() * pct;
		return (x + 99) / 100;
	endfunction

	function automatic logic [MASK_W-1:0] way_run(int base, int len);
		logic [63:0] m;
		if (len == 0 || base >= 32) return '0;
		m = (64'd1 << len) - 64'd1;
		return MASK_W'(m << base);
	endfunction

	function automatic logic [CNT_W-1:0] sat_step(logic [CNT_W-1:0] v, bit up);
		if (up) return (v == '1) ? v : v + 1'b1;
		return (v == '0) ? v : v - 1'b1;
	endfunction

	function automatic void adjust_ways(logic [MASK_W-1:0] m, bit up);
		for (int i = 0; i < eff_ways(); i++)
			if (m[i]) way_ref[i] = sat_step(way_ref[i], up);
	endfunction

	function automatic status_t drop_class(int cls, int cur);
		int c;
		c = eff_classes();
		if (!en_q || cls >= c || cls_ref[cls] == 0 || cur != cls) return ST_REFUSED;
		if (cls == 0 || cls == 1 || cls == c - 1) return ST_PROTECTED;
		adjust_ways(cls_mask[cls], 0);
		cls_ref[cls] = sat_step(cls_ref[cls], 0);
		return ST_OK;
	endfunction

	function automatic void push_res(status_t st, int tc, bit mw, int mc,
			logic [MASK_W-1:0] mb, bit last);
		alloc_res_t r;
		r.st = st; r.tc = CLS_W'(tc); r.mw = mw;
		r.mc = mw ? CLS_W'(mc) : '0;
		r.mb = mw ? mb : '0;
		r.last = last;
		expected_q.push_back(r);
		thread_cls = r.tc;
	endfunction

	function automatic void predict_alloc(mode_t m, int pct, int idx, int cur);
		int w, c, len, cls, base, tb;
		bit found;
		status_t st;
		w = eff_ways();
		c = eff_classes();
		case (m)
			MD_START: begin
				if (!en_q) begin
					push_res(ST_OK, cur, 0, 0, 0, 1);
				end else begin
					tb = share_of(tpct_q > 100 ? 100 : tpct_q);
					cls_mask[0] = tb <= w ? way_run(0, tb) : '0;
					cls_ref[0] = sat_step(cls_ref[0], 1);
					adjust_ways(cls_mask[0], 1);
					cls_mask[c-1] = way_run(0, w);
					cls_ref[c-1] = sat_step(cls_ref[c-1], 1);
					push_res(ST_OK, 0, 1, 0, cls_mask[0], 0);
					push_res(ST_OK, 0, 1, c - 1, cls_mask[c-1], 1);
				end
			end
			MD_ACQUIRE: begin
				if (!en_q || pct > 100) begin
					push_res(ST_REFUSED, cur, 0, 0, 0, 1);
					return;
				end
				if (cur != 0) begin
					st = drop_class(cur, cur);
					if (st != ST_OK) begin
						push_res(st, cur, 0, 0, 0, 1);
						return;
					end
				end
				if (pct == 100) begin
					push_res(ST_OK, c - 1, 0, 0, 0, 1);
					return;
				end
				len = share_of(pct);
				for (cls = 0; cls < c; cls++)
					if (cls_ref[cls] == 0) break;
				if (cls >= c) begin
					push_res(ST_NO_IDLE, 0, 0, 0, 0, 1);
					return;
				end
				found = 0;
				base = 0;
				if (len != 0)
					for (base = 0; base + len <= w; base++) begin
						found = 1;
						for (int i = base; i < base + len; i++)
							if (way_ref[i] != 0) found = 0;
						if (found) break;
					end
				if (!found) begin
					push_res(ST_NO_ROOM, 0, 0, 0, 0, 1);
					return;
				end
				cls_mask[cls] = way_run(base, len);
				cls_ref[cls] = sat_step(cls_ref[cls], 1);
				adjust_ways(cls_mask[cls], 1);
				push_res(ST_OK, cls, 1, cls, cls_mask[cls], 1);
			end
			MD_SELECT: begin
				if (!en_q || idx >= c || cls_ref[idx] == 0)
					push_res(ST_REFUSED, cur, 0, 0, 0, 1);
				else if (idx == 1)
					push_res(ST_PROTECTED, cur, 0, 0, 0, 1);
				else begin
					if (cur != 0) void'(drop_class(cur, cur));
					if (idx != 0 && idx != c - 1) begin
						cls_ref[idx] = sat_step(cls_ref[idx], 1);
						adjust_ways(cls_mask[idx], 1);
					end
					push_res(ST_OK, idx, 0, 0, 0, 1);
				end
			end
			default: begin
				st = drop_class(idx, cur);
				push_res(st, st == ST_OK ? 0 : cur, 0, 0, 0, 1);
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	// result checker and receiver stalls
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		alloc_res_t e;
		if (!arst_n) begin
			res.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_q.size() == 0)
					report_mismatch("unexpected result", res.status, 0);
				else begin
					e = expected_q.pop_front();
					if (res.status !== e.st) report_mismatch("status", res.status, e.st);
					if (res.thread_class !== e.tc)
						report_mismatch("thread_class", res.thread_class, e.tc);
					if (res.mask_write !== e.mw)
						report_mismatch("mask_write", res.mask_write, e.mw);
					if (res.mask_class !== e.mc)
						report_mismatch("mask_class", res.mask_class, e.mc);
					if (res.mask_bits !== e.mb)
						report_mismatch("mask_bits", res.mask_bits, e.mb);
					if (res.last !== e.last) report_mismatch("last", res.last, e.last);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				res.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 6);
				res.ready <= 1'b0;
			end else
				res.ready <= 1'b1;
		end
	end

	task automatic send_req(mode_t m, int pct, int idx, int cur);
		if (idle_on && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 7)) @(posedge clk);
		@(posedge clk);
		req.valid <= 1'b1;
		req.mode <= m;
		req.percent <= 8'(pct);
		req.class_index <= CLS_W'(idx);
		req.current_class <= CLS_W'(cur);
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predict_alloc(m, pct, idx, cur);
		req.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, int value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (index)
			CFG_ENABLED:    en_q = value[0];
			CFG_WAY_COUNT:  ways_q = 6'(value);
			CFG_CLS_COUNT:  classes_q = 5'(value);
			CFG_THREAD_PCT: tpct_q = 7'(value);
			default:        ipct_q = 7'(value);
		endcase
	endtask

	task automatic random_req();
		int r, pct, idx, cur;
		mode_t m;
		r = $urandom_range(0, 99);
		m = r < 8 ? MD_START : r < 50 ? MD_ACQUIRE : r < 70 ? MD_SELECT : MD_RELEASE;
		pct = $urandom_range(0, 9) < 8 ? $urandom_range(1, 100) : $urandom_range(0, 255);
		idx = $urandom_range(0, 9) < 6 ? thread_cls : $urandom_range(0, 15);
		cur = $urandom_range(0, 9) < 8 ? thread_cls : $urandom_range(0, 15);
		send_req(m, pct, idx, cur);
	endtask

	task automatic test_directed();
		int c;
		c = eff_classes();
		send_req(MD_ACQUIRE, 10, 0, 0);
		send_req(MD_START, 0, 0, 0);
		send_req(MD_ACQUIRE, 0, 0, 0);
		send_req(MD_ACQUIRE, 255, 0, 0);
		send_req(MD_ACQUIRE, 101, 0, 0);
		send_req(MD_ACQUIRE, 1, 0, 0);
		send_req(MD_ACQUIRE, 99, 0, thread_cls);
		send_req(MD_ACQUIRE, 20, 0, thread_cls);
		send_req(MD_RELEASE, 0, thread_cls, 5);
		send_req(MD_RELEASE, 0, thread_cls, thread_cls);
		send_req(MD_RELEASE, 0, 0, 0);
		send_req(MD_RELEASE, 0, c - 1, c - 1);
		send_req(MD_SELECT, 0, 1, 0);
		send_req(MD_SELECT, 0, 15, 0);
		send_req(MD_SELECT, 0, c - 1, 0);
		send_req(MD_ACQUIRE, 100, 0, thread_cls);
		send_req(MD_SELECT, 0, 0, thread_cls);
		send_req(MD_ACQUIRE, 30, 0, 0);
		send_req(MD_SELECT, 0, thread_cls, 0);
		send_req(MD_START, 0, 0, 0);
	endtask

	task automatic test_disabled();
		write_reg(CFG_ENABLED, 0);
		send_req(MD_START, 0, 0, 7);
		send_req(MD_ACQUIRE, 50, 0, 3);
		send_req(MD_SELECT, 0, 0, 2);
		send_req(MD_RELEASE, 0, 4, 4);
		write_reg(CFG_ENABLED, 1);
	endtask

	task automatic test_settings();
		int ways_set [5] = '{0, 1, 32, 63, 7};
		int cls_set [5] = '{0, 3, 31, 16, 5};
		int pct_set [5] = '{0, 100, 127, 1, 73};
		for (int s = 0; s < 5; s++) begin
			write_reg(CFG_WAY_COUNT, ways_set[s]);
			write_reg(CFG_CLS_COUNT, cls_set[s]);
			write_reg(CFG_THREAD_PCT, pct_set[s]);
			write_reg(CFG_INT_PCT, pct_set[4 - s]);
			send_req(MD_START, 0, 0, thread_cls);
			repeat (15) random_req();
		end
	endtask

	task automatic test_random_tail();
		write_reg(CFG_WAY_COUNT, 20);
		write_reg(CFG_CLS_COUNT, 16);
		write_reg(CFG_THREAD_PCT, 25);
		repeat (30) random_req();
		idle_on = 0;
		repeat (20) random_req();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.mode = MD_START;
		req.percent = '0;
		req.class_index = '0;
		req.current_class = '0;
		idle_on = 1;
		thread_cls = '0;
		en_q = 1'b1; ways_q = 6'd20; classes_q = 5'd16; tpct_q = 7'd50; ipct_q = 7'd10;
		for (int i = 0; i < MAX_WAYS; i++) way_ref[i] = '0;
		for (int i = 0; i < MAX_CLS; i++) begin
			cls_ref[i] = '0;
			cls_mask[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_disabled();
		test_settings();
		test_random_tail();
		wait_idle();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
